// ----- sv/mpq_pkg.sv -----
package mpq_pkg;

  // default store depth
  localparam int CAPACITY_DEF = 32;

  // field widths
  localparam int OP_W     = 2;
  localparam int CLS_W    = 2;
  localparam int AMOUNT_W = 32;
  localparam int TAG_W    = 64;
  localparam int COUNT_W  = 6;
  localparam int KIND_W   = 2;
  localparam int TDATA_W  = 104;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd3;

  // record class codes
  localparam logic [CLS_W-1:0] CLS_P     = 2'd0;
  localparam logic [CLS_W-1:0] CLS_B     = 2'd1;
  localparam logic [CLS_W-1:0] CLS_G     = 2'd2;
  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd3;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LISTED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd3;

  // one stored record
  typedef struct packed {
    logic [CLS_W-1:0]    cls;
    logic [TAG_W-1:0]    tag;
    logic [AMOUNT_W-1:0] amount;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_EMIT,
    ST_LIST_EMIT,
    ST_CNT_EMIT,
    ST_FULL_EMIT
  } state_t;

endpackage

// ----- sv/max_priority_queue_with_class_counts.sv -----
// Max priority queue of records (class, amount, tag) with live counts of
// classes p, b and g.
// Input channel s_*: one item per command (insert, remove largest, list all
// ascending, report counts). s_tready is high only while the block is idle,
// so one item is worked on at a time.
// Output channel m_*: result items, m_tlast marks the final result of an item.
// A single output register decouples the sides; a stalled receiver holds the
// sequencer in its emit state until the register frees up.
// Steps per item (records live in a memory with one read port):
//   insert: reads the entry below the hole and shifts each larger one up
//     one place (one memory read per shift), then writes the record into
//     the hole; into an empty store the record is written directly
//   insert into a full store: emits one drop result
//   remove largest: memory read at accept, then emit
//   list: emits records in ascending order, reading the next while emitting
//   count report: three results in order b, g, p
// Reset clears fill level, class counts and the output valid flag; the memory
// content needs no clearing since only entries below the fill level are read.
module max_priority_queue_with_class_counts
  import mpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // record_class[1:0], amount[33:2], tag[97:34], zero fill
  input  logic [TDATA_W-1:0] s_tdata,
  // operation[1:0]
  input  logic [OP_W-1:0]    s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // record_class_res[1:0], amount_res[33:2], tag_res[97:34], class_count[103:98]
  output logic [TDATA_W-1:0] m_tdata,
  // kind[1:0]
  output logic [KIND_W-1:0]  m_tuser,
  output logic               m_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t            state, state_next;
  rec_t              cmd_rec;
  logic [AW-1:0]     pos, pos_next;
  logic [1:0]        sel, sel_next;
  logic [CW-1:0]     fill, fill_next;
  logic [CW-1:0]     fill_m1;
  logic [CW-1:0]     counts [3];
  logic [CW-1:0]     counts_next [3];

  logic              o_valid, o_valid_next;
  logic [KIND_W-1:0] o_kind, o_kind_next;
  rec_t              o_rec, o_rec_next;
  logic [COUNT_W-1:0] o_cnt, o_cnt_next;
  logic              o_last, o_last_next;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  rec_t              ram_wd;
  logic              ram_re;
  logic [AW-1:0]     ram_ra;
  rec_t              ram_rd;

  logic [CLS_W-1:0]  cnt_cls;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic              accept;
  logic              rec_last;

  // record memory
  mpq_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wa),
    .wr_data(ram_wd),
    .re     (ram_re),
    .rd_addr(ram_ra),
    .rd_data(ram_rd)
  );

  // handshake and port packing
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !o_valid || m_tready;
  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {o_cnt, o_rec.tag, o_rec.amount, o_rec.cls};
  assign fill_m1  = fill - CW'(1);
  assign rec_last = (CW'(pos) == fill_m1);

  // count report order b, g, p
  always_comb begin
    case (sel)
      2'd0:    cnt_cls = CLS_B;
      2'd1:    cnt_cls = CLS_G;
      default: cnt_cls = CLS_P;
    endcase
    cnt_ext = (CW + COUNT_W)'(counts[cnt_cls]);
  end

  // command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_rec.cls <= s_tdata[1:0];
      cmd_rec.amount <= s_tdata[33:2];
      cmd_rec.tag <= s_tdata[97:34];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      counts  <= '{default: '0};
      o_valid <= 1'b0;
      pos     <= '0;
      sel     <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      counts  <= counts_next;
      o_valid <= o_valid_next;
      pos     <= pos_next;
      sel     <= sel_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    o_kind <= o_kind_next;
    o_rec  <= o_rec_next;
    o_cnt  <= o_cnt_next;
    o_last <= o_last_next;
  end

  // sequencer
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    sel_next     = sel;
    fill_next    = fill;
    counts_next  = counts;
    o_valid_next = o_valid && !m_tready;
    o_kind_next  = o_kind;
    o_rec_next   = o_rec;
    o_cnt_next   = o_cnt;
    o_last_next  = o_last;
    ram_we       = 1'b0;
    ram_wa       = pos;
    ram_wd       = cmd_rec;
    ram_re       = 1'b0;
    ram_ra       = pos;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            OP_INSERT: begin
              if (fill == CW'(CAPACITY)) begin
                state_next = ST_FULL_EMIT;
              end else begin
                pos_next   = fill[AW-1:0];
                state_next = ST_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (fill != '0) begin
                ram_re     = 1'b1;
                ram_ra     = fill_m1[AW-1:0];
                state_next = ST_REM_EMIT;
              end
            end
            OP_LIST: begin
              if (fill != '0) begin
                pos_next   = '0;
                ram_re     = 1'b1;
                ram_ra     = '0;
                state_next = ST_LIST_EMIT;
              end
            end
            OP_COUNT: begin
              sel_next   = '0;
              state_next = ST_CNT_EMIT;
            end
            default: ;
          endcase
        end
      end

      // fetch the entry below the hole, or place the record at the bottom
      ST_INS_RD: begin
        if (pos == '0) begin
          ram_we     = 1'b1;
          ram_wa     = '0;
          ram_wd     = cmd_rec;
          fill_next  = fill + CW'(1);
          if (cmd_rec.cls != CLS_OTHER) begin
            counts_next[cmd_rec.cls] = counts[cmd_rec.cls] + CW'(1);
          end
          state_next = ST_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_ra     = pos - AW'(1);
          state_next = ST_INS_CMP;
        end
      end

      // shift a larger entry up one place, or drop the record into the hole
      ST_INS_CMP: begin
        ram_we = 1'b1;
        ram_wa = pos;
        if (ram_rd.amount > cmd_rec.amount) begin
          ram_wd   = ram_rd;
          pos_next = pos - AW'(1);
          if (pos == AW'(1)) begin
            state_next = ST_INS_RD;
          end else begin
            ram_re = 1'b1;
            ram_ra = pos - AW'(2);
          end
        end else begin
          ram_wd    = cmd_rec;
          fill_next = fill + CW'(1);
          if (cmd_rec.cls != CLS_OTHER) begin
            counts_next[cmd_rec.cls] = counts[cmd_rec.cls] + CW'(1);
          end
          state_next = ST_IDLE;
        end
      end

      // emit the top entry and shrink the store
      ST_REM_EMIT: begin
        if (out_free) begin
          o_valid_next = 1'b1;
          o_kind_next  = KIND_REMOVED;
          o_rec_next   = ram_rd;
          o_cnt_next   = '0;
          o_last_next  = 1'b1;
          fill_next    = fill_m1;
          if (ram_rd.cls != CLS_OTHER && counts[ram_rd.cls] != '0) begin
            counts_next[ram_rd.cls] = counts[ram_rd.cls] - CW'(1);
          end
          state_next = ST_IDLE;
        end
      end

      // emit entry pos while the next one is read
      ST_LIST_EMIT: begin
        if (out_free) begin
          o_valid_next = 1'b1;
          o_kind_next  = KIND_LISTED;
          o_rec_next   = ram_rd;
          o_cnt_next   = '0;
          o_last_next  = rec_last;
          if (rec_last) begin
            state_next = ST_IDLE;
          end else begin
            pos_next = pos + AW'(1);
            ram_re   = 1'b1;
            ram_ra   = pos + AW'(1);
          end
        end
      end

      // three count results
      ST_CNT_EMIT: begin
        if (out_free) begin
          o_valid_next      = 1'b1;
          o_kind_next       = KIND_COUNT;
          o_rec_next.cls    = cnt_cls;
          o_rec_next.amount = '0;
          o_rec_next.tag    = '0;
          o_cnt_next        = cnt_ext[COUNT_W-1:0];
          o_last_next       = (sel == 2'd2);
          sel_next          = sel + 2'd1;
          if (sel == 2'd2) begin
            state_next = ST_IDLE;
          end
        end
      end

      // echo the dropped record
      ST_FULL_EMIT: begin
        if (out_free) begin
          o_valid_next = 1'b1;
          o_kind_next  = KIND_FULL;
          o_rec_next   = cmd_rec;
          o_cnt_next   = '0;
          o_last_next  = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/mpq_ram.sv -----
module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- verif/tb_max_priority_queue_with_class_counts.sv -----
module tb_max_priority_queue_with_class_counts;
  import mpq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;
  localparam int AMT_LSB     = CLS_W;
  localparam int TAG_LSB     = CLS_W + AMOUNT_W;
  localparam int CNT_LSB     = CLS_W + AMOUNT_W + TAG_W;

  // one result item as the block should emit it
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [CLS_W-1:0]    cls;
    logic [AMOUNT_W-1:0] amount;
    logic [TAG_W-1:0]    tag;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // record_class, amount, tag, zero fill
  logic [TDATA_W-1:0] s_tdata = '0;
  // operation
  logic [OP_W-1:0]    s_tuser = OP_INSERT;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // record_class_res, amount_res, tag_res, class_count
  logic [TDATA_W-1:0] m_tdata;
  // kind
  logic [KIND_W-1:0]  m_tuser;
  logic               m_tlast;

  // queue contents in ascending amount order, ties oldest first
  rec_t    held_recs[$];
  int      class_tally[3];
  result_t pending_results[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int level_est = 0;
  bit steady = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  max_priority_queue_with_class_counts dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // run limit
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("[max_priority_queue_with_class_counts] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic push_result(input logic [KIND_W-1:0] kind, input logic [CLS_W-1:0] cls,
                             input logic [AMOUNT_W-1:0] amt, input logic [TAG_W-1:0] tg,
                             input logic [COUNT_W-1:0] cnt, input logic last);
    result_t r;
    r.kind = kind;
    r.cls = cls;
    r.amount = amt;
    r.tag = tg;
    r.count = cnt;
    r.last = last;
    pending_results.push_back(r);
  endtask

  // expected results of one accepted item, and the queue update it causes
  task automatic predict_item(input logic [OP_W-1:0] op, input logic [CLS_W-1:0] cls,
                              input logic [AMOUNT_W-1:0] amt, input logic [TAG_W-1:0] tg);
    rec_t r;
    int   pos;
    case (op)
      OP_INSERT: begin
        if (held_recs.size() >= DEPTH) begin
          push_result(KIND_FULL, cls, amt, tg, '0, 1'b1);
        end else begin
          r.cls = cls;
          r.tag = tg;
          r.amount = amt;
          // goes after every record with an amount not above it
          pos = held_recs.size();
          while (pos > 0 && held_recs[pos-1].amount > amt) pos--;
          held_recs.insert(pos, r);
          if (cls != CLS_OTHER) class_tally[cls]++;
        end
      end
      OP_REMOVE: begin
        if (held_recs.size() > 0) begin
          r = held_recs.pop_back();
          push_result(KIND_REMOVED, r.cls, r.amount, r.tag, '0, 1'b1);
          if (r.cls != CLS_OTHER && class_tally[r.cls] > 0) class_tally[r.cls]--;
        end
      end
      OP_LIST: begin
        for (int i = 0; i < held_recs.size(); i++)
          push_result(KIND_LISTED, held_recs[i].cls, held_recs[i].amount, held_recs[i].tag,
                      '0, i == held_recs.size() - 1);
      end
      default: begin
        push_result(KIND_COUNT, CLS_B, '0, '0, COUNT_W'(class_tally[CLS_B]), 1'b0);
        push_result(KIND_COUNT, CLS_G, '0, '0, COUNT_W'(class_tally[CLS_G]), 1'b0);
        push_result(KIND_COUNT, CLS_P, '0, '0, COUNT_W'(class_tally[CLS_P]), 1'b1);
      end
    endcase
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: kind %0d cls %0d amt %h tag %h",
                                got.kind, got.cls, got.amount, got.tag));
    end else begin
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.cls !== want.cls || got.amount !== want.amount ||
          got.tag !== want.tag || got.count !== want.count || got.last !== want.last)
        report_mismatch($sformatf(
          "got k%0d c%0d a%h t%h n%0d l%0d, want k%0d c%0d a%h t%h n%0d l%0d",
          got.kind, got.cls, got.amount, got.tag, got.count, got.last,
          want.kind, want.cls, want.amount, want.tag, want.count, want.last));
    end
  endtask

  // watch both handshakes, results first
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.cls = m_tdata[CLS_W-1:0];
        got.amount = m_tdata[AMT_LSB +: AMOUNT_W];
        got.tag = m_tdata[TAG_LSB +: TAG_W];
        got.count = m_tdata[CNT_LSB +: COUNT_W];
        got.last = m_tlast;
        check_result(got);
      end
      if (s_tvalid && s_tready)
        predict_item(s_tuser, s_tdata[CLS_W-1:0], s_tdata[AMT_LSB +: AMOUNT_W],
                     s_tdata[TAG_LSB +: TAG_W]);
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_pending) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_pending <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 28);
    end
  end

  // offer one item, with a random gap first, and wait until it is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CLS_W-1:0] cls,
                           input logic [AMOUNT_W-1:0] amt, input logic [TAG_W-1:0] tg);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(TDATA_W - CNT_LSB){1'b0}}, tg, amt, cls};
    do @(posedge clk); while (!s_tready);
    if (op == OP_INSERT && level_est < DEPTH) level_est++;
    if (op == OP_REMOVE && level_est > 0) level_est--;
  endtask

  function automatic logic [AMOUNT_W-1:0] rand_amount();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(15);
      4:          return '0;
      5:          return '1;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    return {$urandom, $urandom};
  endfunction

  // remove, list and count on an empty queue
  task automatic test_empty_store();
    send_item(OP_REMOVE, CLS_P, '0, '0);
    send_item(OP_LIST, CLS_B, '1, '1);
    send_item(OP_COUNT, CLS_G, '0, '0);
  endtask

  // extreme fields, every class, equal amounts and removal order among them
  task automatic test_extremes_and_ties();
    send_item(OP_INSERT, CLS_P, '0, '0);
    send_item(OP_INSERT, CLS_B, '1, '1);
    send_item(OP_INSERT, CLS_G, 32'd100, 64'h1);
    send_item(OP_INSERT, CLS_OTHER, 32'd100, 64'h2);
    send_item(OP_INSERT, CLS_P, 32'd100, 64'h3);
    send_item(OP_INSERT, CLS_B, '1, 64'h5555_5555_5555_5555);
    send_item(OP_INSERT, CLS_OTHER, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_LIST, CLS_P, '0, '0);
    send_item(OP_COUNT, CLS_P, '0, '0);
    // newest of the equal maxima leaves first
    for (int i = 0; i < 4; i++) send_item(OP_REMOVE, CLS_P, '0, '0);
    send_item(OP_LIST, CLS_P, '0, '0);
    send_item(OP_COUNT, CLS_P, '0, '0);
    for (int i = 0; i < 4; i++) send_item(OP_REMOVE, CLS_P, '0, '0);
    send_item(OP_COUNT, CLS_P, '0, '0);
  endtask

  // receiver holds off during a count report, then the queue fills up and overflows
  task automatic test_backpressure_fill();
    hold_pending <= 1'b1;
    send_item(OP_COUNT, CLS_P, '0, '0);
    for (int i = 0; i < DEPTH + 3; i++)
      send_item(OP_INSERT, CLS_W'($urandom_range(3)), rand_amount(), rand_tag());
    send_item(OP_LIST, CLS_P, '0, '0);
    send_item(OP_COUNT, CLS_P, '0, '0);
  endtask

  // random operations in alternating fill and drain phases
  task automatic test_random_mix(input int n_items);
    bit filling;
    int roll;
    logic [OP_W-1:0] op;
    filling = (level_est < DEPTH / 2);
    for (int i = 0; i < n_items; i++) begin
      if (level_est == 0) filling = 1'b1;
      else if (level_est >= DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      roll = $urandom_range(99);
      if (filling)
        op = (roll < 70) ? OP_INSERT : (roll < 82) ? OP_REMOVE : (roll < 90) ? OP_LIST : OP_COUNT;
      else
        op = (roll < 20) ? OP_INSERT : (roll < 75) ? OP_REMOVE : (roll < 85) ? OP_LIST : OP_COUNT;
      send_item(op, CLS_W'($urandom_range(3)), rand_amount(), rand_tag());
    end
  endtask

  // both sides run without stalls for a while
  task automatic test_no_idle_stretch();
    steady = 1'b1;
    test_random_mix(60);
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_extremes_and_ties();
    test_backpressure_fill();
    test_no_idle_stretch();
    test_random_mix(130);
    s_tvalid <= 1'b0;
    // drain, then allow for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[max_priority_queue_with_class_counts] OK");
    end else begin
      $display("[max_priority_queue_with_class_counts] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mpq_pkg.sv
sv/mpq_ram.sv
sv/max_priority_queue_with_class_counts.sv
verif/tb_max_priority_queue_with_class_counts.sv
